FILE: hdl/bilinear_table_interpolation_defines.svh
// ----------------------------------------------------------------------------
// Bilinear table interpolation assertion macros
// Shared concurrent assertion forms for the interpolation block.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TABLE_INTERPOLATION_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bilinear_table_interpolation: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bilinear_table_interpolation: assertion failed");

`endif

FILE: hdl/bti_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear table interpolation package
// Map dimensions, derived widths, opcodes, states and word types.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int ROW_POINTS = 16;
    localparam int COL_POINTS = 16;
    localparam int MAX_POINTS = (ROW_POINTS > COL_POINTS) ? ROW_POINTS : COL_POINTS;

    localparam int ROW_AW  = $clog2(ROW_POINTS);
    localparam int COL_AW  = $clog2(COL_POINTS);
    localparam int CELL_AW = $clog2(ROW_POINTS * COL_POINTS);

    // The scan counter must reach MAX_POINTS; the divider needs 16 steps.
    localparam int SCAN_W = $clog2(MAX_POINTS + 1);
    localparam int STEP_W = (SCAN_W > 4) ? SCAN_W : 4;

    localparam int DIV_STEPS = 16;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // Last step of the cell read and blend sequence.
    localparam int CELL_LAST = 6;

    typedef enum logic [1:0] {
        OP_WRITE_CELL = 2'd0,
        OP_WRITE_ROW  = 2'd1,
        OP_WRITE_COL  = 2'd2,
        OP_LOOKUP     = 2'd3
    } bti_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIV,
        ST_CELL,
        ST_DONE
    } bti_state_t;

    typedef struct packed {
        bti_op_t     opcode;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [15:0] write_value;
        logic [15:0] row_coord;
        logic [15:0] col_coord;
    } bti_in_t;

    typedef struct packed {
        logic [15:0] interp_value;
        logic [3:0]  row_segment;
        logic [3:0]  col_segment;
        logic        degenerate_axis;
    } bti_out_t;

    // Classification of one axis segment before the weight division.
    typedef struct packed {
        logic        flat;
        logic        one;
        logic        use_div;
        logic [15:0] an;
        logic [15:0] ad;
    } bti_prep_t;

    // One restoring division step: new remainder and quotient.
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] quo;
    } bti_div_t;

endpackage

FILE: hdl/bti_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/bilinear_table_interpolation.sv
// Write words are taken one per cycle while the block is idle, complete at
// acceptance and return nothing. A lookup word runs an axis scan through the
// breakpoint RAMs, a 16-step restoring division per axis, then four cell RAM
// reads. No new word is taken until the lookup result has been loaded into the
// output register, which waits for the previous result to be taken.
// Reset clears control state only; map and axis contents are kept.
// ----------------------------------------------------------------------------
// Bilinear table interpolation
// Breakpoint search, clamped Q1.16 axis weights and a rounded bilinear blend.
// ----------------------------------------------------------------------------
`include "bilinear_table_interpolation_defines.svh"

module bilinear_table_interpolation (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bti_pkg::bti_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bti_pkg::bti_out_t m_data
);

    import bti_pkg::*;

    bti_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;

    logic              s_accept;
    logic              out_free;
    logic              out_load;

    logic [15:0]       rc_reg, cc_reg;
    logic [15:0]       row_prev_reg, col_prev_reg;
    logic [15:0]       rlo_reg, rhi_reg, clo_reg, chi_reg;
    logic [ROW_AW-1:0] rseg_reg;
    logic [COL_AW-1:0] cseg_reg;

    logic              rone_reg, ruse_reg, cone_reg, cuse_reg;
    logic              flat_reg;
    logic [15:0]       rrem_reg, rad_reg, rquo_reg;
    logic [15:0]       crem_reg, cad_reg, cquo_reg;
    logic [16:0]       wr_reg, wc_reg;

    logic [31:0]       prod_reg, inner_reg, rowsum_reg;
    logic [47:0]       acc_reg;

    logic              m_valid_reg;
    bti_out_t          m_data_reg;

    bti_prep_t         rprep, cprep;
    bti_div_t          rdiv, cdiv;
    logic [47:0]       rounded;
    int                scan_pos;

    logic              row_we, col_we, cell_we;
    logic [15:0]       row_rdata, col_rdata, cell_rdata;
    logic [CELL_AW-1:0] cell_waddr, cell_raddr;
    logic [16:0]       cell_weight;

    function automatic bti_prep_t axis_prep(logic [15:0] coord, logic [15:0] lo,
                                            logic [15:0] hi);
        logic [16:0] num;
        logic [16:0] den;
        logic [16:0] an;
        logic [16:0] ad;
        logic        zero;
        bti_prep_t   p;
        num  = {1'b0, coord} - {1'b0, lo};
        den  = {1'b0, hi} - {1'b0, lo};
        an   = num[16] ? 17'(-num) : num;
        ad   = den[16] ? 17'(-den) : den;
        zero = (num == 17'd0) || (num[16] != den[16]);
        p.flat    = (den == 17'd0);
        p.one     = !p.flat && !zero && (an >= ad);
        p.use_div = !p.flat && !zero && (an < ad);
        p.an      = an[15:0];
        p.ad      = ad[15:0];
        return p;
    endfunction

    function automatic bti_div_t div_step(logic [15:0] rem, logic [15:0] quo,
                                          logic [15:0] ad);
        logic [16:0] sh;
        logic        ge;
        bti_div_t    d;
        sh    = {rem, 1'b0};
        ge    = (sh >= {1'b0, ad});
        d.rem = ge ? 16'(sh - {1'b0, ad}) : sh[15:0];
        d.quo = {quo[14:0], ge};
        return d;
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    assign row_we  = s_accept && (s_data.opcode == OP_WRITE_ROW)
                     && (32'(s_data.row_index) < ROW_POINTS);
    assign col_we  = s_accept && (s_data.opcode == OP_WRITE_COL)
                     && (32'(s_data.col_index) < COL_POINTS);
    assign cell_we = s_accept && (s_data.opcode == OP_WRITE_CELL)
                     && (32'(s_data.row_index) < ROW_POINTS)
                     && (32'(s_data.col_index) < COL_POINTS);

    assign cell_waddr = CELL_AW'(32'(s_data.row_index) * COL_POINTS
                                 + 32'(s_data.col_index));

    // Cell reads walk (r,c), (r,c+1), (r+1,c), (r+1,c+1) on step bits 1 and 0.
    assign cell_raddr = CELL_AW'((32'(rseg_reg) + 32'(step_cnt_reg[1])) * COL_POINTS
                                 + 32'(cseg_reg) + 32'(step_cnt_reg[0]));

    bti_ram #(.WIDTH(16), .DEPTH(ROW_POINTS)) u_row_axis (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (ROW_AW'(s_data.row_index)),
        .wdata (s_data.write_value),
        .raddr (ROW_AW'(step_cnt_reg)),
        .rdata (row_rdata)
    );

    bti_ram #(.WIDTH(16), .DEPTH(COL_POINTS)) u_col_axis (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (COL_AW'(s_data.col_index)),
        .wdata (s_data.write_value),
        .raddr (COL_AW'(step_cnt_reg)),
        .rdata (col_rdata)
    );

    bti_ram #(.WIDTH(16), .DEPTH(ROW_POINTS * COL_POINTS)) u_cell (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (s_data.write_value),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg + STEP_W'(1);
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                step_cnt_next = '0;
                if (s_accept && (s_data.opcode == OP_LOOKUP)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step_cnt_reg == STEP_W'(MAX_POINTS)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next    = ST_DIV;
                step_cnt_next = '0;
            end
            ST_DIV: begin
                if (step_cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next    = ST_CELL;
                    step_cnt_next = '0;
                end
            end
            ST_CELL: begin
                if (step_cnt_reg == STEP_W'(CELL_LAST)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                step_cnt_next = '0;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                step_cnt_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign scan_pos = 32'(step_cnt_reg);
    assign rprep    = axis_prep(rc_reg, rlo_reg, rhi_reg);
    assign cprep    = axis_prep(cc_reg, clo_reg, chi_reg);
    assign rdiv     = div_step(rrem_reg, rquo_reg, rad_reg);
    assign cdiv     = div_step(crem_reg, cquo_reg, cad_reg);
    assign rounded  = acc_reg + 48'h0000_8000_0000;

    // Column weight for the cell whose data arrives this step.
    assign cell_weight = step_cnt_reg[0] ? (WEIGHT_ONE - wc_reg) : wc_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rc_reg <= s_data.row_coord;
            cc_reg <= s_data.col_coord;
        end

        if (state_reg == ST_SCAN) begin
            // Read data for axis index scan_pos - 1 is on the RAM output now.
            if (scan_pos >= 1 && scan_pos <= ROW_POINTS) begin
                row_prev_reg <= row_rdata;
            end
            if (scan_pos == 2 ||
                (scan_pos >= 3 && scan_pos <= ROW_POINTS && rc_reg >= row_prev_reg)) begin
                rseg_reg <= ROW_AW'(scan_pos - 2);
                rlo_reg  <= row_prev_reg;
                rhi_reg  <= row_rdata;
            end
            if (scan_pos >= 1 && scan_pos <= COL_POINTS) begin
                col_prev_reg <= col_rdata;
            end
            if (scan_pos == 2 ||
                (scan_pos >= 3 && scan_pos <= COL_POINTS && cc_reg >= col_prev_reg)) begin
                cseg_reg <= COL_AW'(scan_pos - 2);
                clo_reg  <= col_prev_reg;
                chi_reg  <= col_rdata;
            end
        end

        if (state_reg == ST_PREP) begin
            rone_reg <= rprep.one;
            ruse_reg <= rprep.use_div;
            rrem_reg <= rprep.use_div ? rprep.an : 16'd0;
            rad_reg  <= rprep.ad;
            rquo_reg <= '0;
            cone_reg <= cprep.one;
            cuse_reg <= cprep.use_div;
            crem_reg <= cprep.use_div ? cprep.an : 16'd0;
            cad_reg  <= cprep.ad;
            cquo_reg <= '0;
            flat_reg <= rprep.flat || cprep.flat;
        end

        if (state_reg == ST_DIV) begin
            rrem_reg <= rdiv.rem;
            rquo_reg <= rdiv.quo;
            crem_reg <= cdiv.rem;
            cquo_reg <= cdiv.quo;
            if (step_cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                wr_reg <= rone_reg ? WEIGHT_ONE : (ruse_reg ? {1'b0, rdiv.quo} : 17'd0);
                wc_reg <= cone_reg ? WEIGHT_ONE : (cuse_reg ? {1'b0, cdiv.quo} : 17'd0);
            end
        end

        if (state_reg == ST_CELL) begin
            // Cells arrive on steps 1..4; row sums close on steps 3 and 5 and
            // are scaled by the row weights on steps 4 and 6.
            if (scan_pos >= 1 && scan_pos <= 4) begin
                prod_reg <= 32'({16'd0, cell_rdata} * {15'd0, cell_weight});
            end
            if (scan_pos == 2 || scan_pos == 4) begin
                inner_reg <= prod_reg;
            end
            if (scan_pos == 3 || scan_pos == 5) begin
                rowsum_reg <= inner_reg + prod_reg;
            end
            if (scan_pos == 4) begin
                acc_reg <= {16'd0, rowsum_reg} * {31'd0, WEIGHT_ONE - wr_reg};
            end
            if (scan_pos == CELL_LAST) begin
                acc_reg <= acc_reg + {16'd0, rowsum_reg} * {31'd0, wr_reg};
            end
        end

        if (out_load) begin
            m_data_reg.interp_value    <= rounded[47:32];
            m_data_reg.row_segment     <= 4'(rseg_reg);
            m_data_reg.col_segment     <= 4'(cseg_reg);
            m_data_reg.degenerate_axis <= flat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BTI_ASSERT_NEXT(a_lookup_starts_scan, aclk, aresetn,
                     s_accept && (s_data.opcode == OP_LOOKUP), state_reg == ST_SCAN)
    `BTI_ASSERT_IMPL(a_result_from_done, aclk, aresetn,
                     $rose(m_valid_reg), $past(state_reg) == ST_DONE)
    `BTI_ASSERT_IMPL(a_div_remainder, aclk, aresetn,
                     (state_reg == ST_DIV) && ruse_reg, rrem_reg < rad_reg)
    `BTI_ASSERT_IMPL(a_segment_range, aclk, aresetn, state_reg == ST_DONE,
                     (32'(rseg_reg) <= ROW_POINTS - 2) && (32'(cseg_reg) <= COL_POINTS - 2))

endmodule
